>>> hdl/lfx_pkg.sv
package lfx_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W;

    // field widths
    localparam int WORD_W  = 16;
    localparam int LEN_W   = 6;
    localparam int LEVEL_W = 6;
    localparam int CMD_W   = 2;
    localparam int S_DW    = 16;
    localparam int M_DW    = 48;

    // configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_MARKER = 2'd0;
    localparam logic [1:0] REG_FRAME  = 2'd1;
    localparam logic [1:0] REG_FILL   = 2'd2;

    localparam logic [WORD_W-1:0] MARKER_RST = 16'h102A;
    localparam logic [LEN_W-1:0]  FRAME_RST  = 6'd8;
    localparam logic [WORD_W-1:0] FILL_RST   = 16'hFFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_LINK = 2'd0,
        CMD_PUSH = 2'd1,
        CMD_POP  = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REPLY_STANDBY = 2'd0,
        REPLY_QUEUED  = 2'd1,
        REPLY_IDLE    = 2'd2
    } reply_mode_t;

    typedef struct packed {
        logic             full;
        logic             empty;
        logic [CNT_W-1:0] count;
    } queue_status_t;

    function automatic logic [LEVEL_W-1:0] level_out(input logic [CNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[LEVEL_W-1:0];
    endfunction

endpackage

>>> hdl/link_frame_exchange_slave.sv
// slave side of a framed word exchange over a serial link
//
// input stream (s_*): one transaction per link word or host access, the
// command in tuser selects a received link word, a host push into the send
// queue, a host pop from the receive queue, or no operation; tdata carries the word
// output stream (m_*): exactly one result transaction per input transaction,
// carrying the reply word loaded for the link, the popped word, both queue
// levels, the overflow flag and the frame status
// configuration: apb-style port, marker at 0x0, frame length at 0x4, idle
// fill word at 0x8; pready is always high, reads return the register value
// timing: an accepted transaction waits for the registered read of the queue
// memories, then loads the output register once it is free; a new transaction
// is accepted only after the previous result has been loaded
// reset: queues empty, standby, registers at their reset values; no clearing
// pass is needed because queue entries are only read after being written
// stall: a waiting result sits in the output register while the next item is
// accepted and processed; its result then waits until the register frees
module link_frame_exchange_slave (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // data [15:0]
    input  logic [lfx_pkg::S_DW-1:0]    s_tdata,
    // command [1:0]
    input  logic [lfx_pkg::CMD_W-1:0]   s_tuser,
    // tx_word [15:0], tx_load [16], read_word [32:17], read_valid [33],
    // send_level [39:34], recv_level [45:40], overflow [46], in_frame [47]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lfx_pkg::M_DW-1:0]    m_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfx_pkg::APB_AW-1:0]  paddr,
    input  logic [lfx_pkg::APB_DW-1:0]  pwdata,
    output logic [lfx_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import lfx_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WAIT = 2'b10
    } state_t;

    // configuration registers
    logic [WORD_W-1:0] marker_reg;
    logic [LEN_W-1:0]  frame_reg;
    logic [WORD_W-1:0] fill_reg;
    logic              cfg_wr;
    logic [1:0]        cfg_idx;

    // link protocol state
    state_t            state_reg, state_next;
    logic              receiving_reg, receiving_next;
    logic [LEN_W-1:0]  rx_rem_reg, rx_rem_next;
    reply_mode_t       mode_reg, mode_next;
    logic [LEN_W-1:0]  reply_rem_reg, reply_rem_next;

    // pending result pieces, completed once the memory read returns
    logic              pend_tx_load_reg, pend_tx_load_next;
    logic              pend_tx_ram_reg, pend_tx_ram_next;
    logic [WORD_W-1:0] pend_tx_word_reg, pend_tx_word_next;
    logic              pend_rd_ram_reg, pend_rd_ram_next;
    logic              pend_ovf_reg, pend_ovf_next;

    // output register
    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_DW-1:0]   m_tdata_reg, m_tdata_next;

    // decode of the accepted transaction
    logic              accept, link, start, recv_push, send_push, send_pop, recv_pop;
    logic              reply_active, out_load;
    cmd_t              cmd;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len, reply_rem_eff, reply_rem_dec;
    reply_mode_t       mode_eff;

    logic [WORD_W-1:0] send_rdata, recv_rdata, tx_word_out, rd_word_out;
    queue_status_t     send_st, recv_st;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= MARKER_RST;
            frame_reg  <= FRAME_RST;
            fill_reg   <= FILL_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MARKER: marker_reg <= pwdata[WORD_W-1:0];
                REG_FRAME:  frame_reg  <= pwdata[LEN_W-1:0];
                REG_FILL:   fill_reg   <= pwdata[WORD_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_MARKER: prdata = APB_DW'(marker_reg);
            REG_FRAME:  prdata = APB_DW'(frame_reg);
            REG_FILL:   prdata = APB_DW'(fill_reg);
            default:    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // decode and link protocol, evaluated in the accept cycle
    // ---------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);
    assign word     = s_tdata[WORD_W-1:0];

    // a frame length of zero counts as one
    assign len = (frame_reg == '0) ? LEN_W'(1) : frame_reg;

    assign link      = accept && (cmd == CMD_LINK);
    assign start     = link && !receiving_reg && (word == marker_reg);
    assign recv_push = link && receiving_reg;
    assign send_push = accept && (cmd == CMD_PUSH);
    assign recv_pop  = accept && (cmd == CMD_POP);

    // reply mode is chosen on the marker and the first reply word goes out on it
    always_comb
    begin
        if (start)
        begin
            mode_eff      = (32'(send_st.count) >= 32'(len)) ? REPLY_QUEUED : REPLY_IDLE;
            reply_rem_eff = len;
        end
        else
        begin
            mode_eff      = mode_reg;
            reply_rem_eff = reply_rem_reg;
        end
    end

    assign reply_active  = link && (mode_eff != REPLY_STANDBY);
    assign send_pop      = reply_active && (mode_eff == REPLY_QUEUED);
    assign reply_rem_dec = reply_rem_eff - 1'b1;

    always_comb
    begin
        receiving_next = receiving_reg;
        rx_rem_next    = rx_rem_reg;
        mode_next      = mode_reg;
        reply_rem_next = reply_rem_reg;

        if (start)
        begin
            receiving_next = 1'b1;
            rx_rem_next    = len;
        end
        else if (recv_push)
        begin
            // a dropped word still counts toward the frame
            rx_rem_next = rx_rem_reg - 1'b1;
            if (rx_rem_next == '0)
            begin
                receiving_next = 1'b0;
            end
        end

        if (reply_active)
        begin
            reply_rem_next = reply_rem_dec;
            mode_next      = (reply_rem_dec == '0) ? REPLY_STANDBY : mode_eff;
        end
        else if (link)
        begin
            mode_next = REPLY_STANDBY;
        end
    end

    // ---------------------------------------------------------------
    // sequencing and result assembly
    // ---------------------------------------------------------------
    assign out_load = (state_reg == ST_WAIT) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next        = state_reg;
        pend_tx_load_next = pend_tx_load_reg;
        pend_tx_ram_next  = pend_tx_ram_reg;
        pend_tx_word_next = pend_tx_word_reg;
        pend_rd_ram_next  = pend_rd_ram_reg;
        pend_ovf_next     = pend_ovf_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next        = ST_WAIT;
                    pend_tx_load_next = reply_active;
                    pend_tx_ram_next  = send_pop && !send_st.empty;
                    // idle fill, or zero when queued mode finds the queue empty
                    pend_tx_word_next = (reply_active && (mode_eff == REPLY_IDLE))
                                        ? fill_reg : '0;
                    pend_rd_ram_next  = recv_pop && !recv_st.empty;
                    pend_ovf_next     = (send_push && send_st.full)
                                        || (recv_push && recv_st.full);
                end
            end
            ST_WAIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign tx_word_out = pend_tx_ram_reg ? send_rdata : pend_tx_word_reg;
    assign rd_word_out = pend_rd_ram_reg ? recv_rdata : '0;

    // levels and frame status are read after the step has updated them
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {receiving_reg,
                             pend_ovf_reg,
                             level_out(recv_st.count),
                             level_out(send_st.count),
                             pend_rd_ram_reg,
                             rd_word_out,
                             pend_tx_load_reg,
                             tx_word_out};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            receiving_reg <= 1'b0;
            rx_rem_reg    <= '0;
            mode_reg      <= REPLY_STANDBY;
            reply_rem_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            receiving_reg <= receiving_next;
            rx_rem_reg    <= rx_rem_next;
            mode_reg      <= mode_next;
            reply_rem_reg <= reply_rem_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_tx_load_reg <= pend_tx_load_next;
        pend_tx_ram_reg  <= pend_tx_ram_next;
        pend_tx_word_reg <= pend_tx_word_next;
        pend_rd_ram_reg  <= pend_rd_ram_next;
        pend_ovf_reg     <= pend_ovf_next;
        m_tdata_reg      <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------
    // queues: send (host to link) and receive (link to host)
    // ---------------------------------------------------------------
    lfx_queue u_send_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (send_push),
        .pop    (send_pop),
        .wdata  (word),
        .rdata  (send_rdata),
        .status (send_st)
    );

    lfx_queue u_recv_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (recv_push),
        .pop    (recv_pop),
        .wdata  (word),
        .rdata  (recv_rdata),
        .status (recv_st)
    );

endmodule

>>> hdl/lfx_ram.sv
module lfx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/lfx_queue.sv
module lfx_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic                         pop,
    input  logic [lfx_pkg::WORD_W-1:0]   wdata,
    output logic [lfx_pkg::WORD_W-1:0]   rdata,
    output lfx_pkg::queue_status_t       status
);
    import lfx_pkg::*;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             full, empty, push_ok, pop_ok;

    assign full    = (32'(count_reg) == QUEUE_DEPTH - 1);
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;

    // ring pointers wrap at the depth, which need not be a power of two
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push_ok)
        begin
            tail_next = (32'(tail_reg) == QUEUE_DEPTH - 1) ? '0 : tail_reg + 1'b1;
        end
        if (pop_ok)
        begin
            head_next = (32'(head_reg) == QUEUE_DEPTH - 1) ? '0 : head_reg + 1'b1;
        end
        unique case ({push_ok, pop_ok})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    lfx_ram #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (push_ok),
        .waddr (tail_reg),
        .wdata (wdata),
        .re    (pop_ok),
        .raddr (head_reg),
        .rdata (rdata)
    );

    assign status.full  = full;
    assign status.empty = empty;
    assign status.count = count_reg;

endmodule

>>> hdl/lfx_checker.sv
module lfx_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [lfx_pkg::M_DW-1:0]    m_tdata
);
    import lfx_pkg::*;

    // one item in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while previous item still in work");

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result withdrawn under stall");

    // no reply load means a zero reply word
    a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[16]) |-> (m_tdata[15:0] == '0))
        else $error("reply word without load flag");

    // an empty or absent pop returns zero
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[33]) |-> (m_tdata[32:17] == '0))
        else $error("read word without read flag");

endmodule

bind link_frame_exchange_slave lfx_checker u_checker (.*);
